// File: design/p3te_pkg.sv
package p3te_pkg;

    localparam int TILES_ACROSS_DEF = 16;
    localparam int BAND_COUNT_DEF   = 4;

    localparam int GROUP_W  = 32;
    localparam int ENTRY_W  = 24;
    localparam int CHUNK_W  = 24;
    localparam int OFFSET_W = 11;
    localparam int PIXELS   = 8;
    localparam int CHUNK_BYTES_N = 3;

    typedef enum logic {
        OP_PIXELS = 1'b0,
        OP_DRAIN  = 1'b1
    } t_opcode;

    typedef struct packed {
        logic       odd;
        logic [1:0] plane;
    } t_byte_sel;

    typedef struct packed {
        t_byte_sel [CHUNK_BYTES_N-1:0] sel;
        logic [OFFSET_W-1:0]           offset;
        logic                          last;
    } t_chunk_meta;

endpackage

// File: design/p3te_if.sv
interface p3te_pix_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [p3te_pkg::GROUP_W-1:0] pixel_group;

    modport source (output valid, output opcode, output pixel_group, input ready);
    modport sink   (input valid, input opcode, input pixel_group, output ready);
endinterface

interface p3te_chunk_if;
    logic                          valid;
    logic                          ready;
    logic [p3te_pkg::CHUNK_W-1:0]  chunk_bytes;
    logic [p3te_pkg::OFFSET_W-1:0] byte_offset;
    logic                          is_last;

    modport source (output valid, output chunk_bytes, output byte_offset, output is_last,
                    input ready);
    modport sink   (input valid, input chunk_bytes, input byte_offset, input is_last,
                    output ready);
endinterface

// File: design/p3te_ctrl.sv
module p3te_ctrl #(
    parameter int TILES_ACROSS = p3te_pkg::TILES_ACROSS_DEF,
    parameter int BAND_COUNT   = p3te_pkg::BAND_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_opcode,
    input  logic [p3te_pkg::GROUP_W-1:0] i_pixel_group,
    input  logic                         i_s1_free,
    output logic                         o_ready,
    output logic                         o_wr_en,
    output logic                         o_wr_odd,
    output logic [((TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1)+2:0] o_wr_addr,
    output logic [p3te_pkg::ENTRY_W-1:0] o_wr_data,
    output logic                         o_rd_en,
    output logic [((TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1)+2:0] o_rd_addr_even,
    output logic [((TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1)+2:0] o_rd_addr_odd,
    output logic [((TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1)+2:0] o_rd_addr_third,
    output p3te_pkg::t_chunk_meta        o_meta
);

    localparam int TILE_W = (TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1;
    localparam int BAND_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
    localparam int AW     = TILE_W + 3;
    localparam int OW     = p3te_pkg::OFFSET_W;
    localparam int NB     = p3te_pkg::CHUNK_BYTES_N;
    localparam logic [TILE_W-1:0] TILE_LAST  = TILE_W'(TILES_ACROSS - 1);
    localparam logic [BAND_W-1:0] BAND_LAST  = BAND_W'(BAND_COUNT - 1);
    localparam logic [OW-1:0]     BAND_BYTES = OW'((TILES_ACROSS * 24) % (2 ** OW));

    logic              r_wr_half, n_wr_half;
    logic [2:0]        r_wr_row, n_wr_row;
    logic [TILE_W-1:0] r_wr_tile, n_wr_tile;
    logic [BAND_W-1:0] r_wr_band, n_wr_band;
    logic [OW-1:0]     r_band_base, n_band_base;
    logic              r_pending, n_pending;
    logic [2:0]        r_rd_k, n_rd_k;
    logic [TILE_W-1:0] r_rd_tile, n_rd_tile;
    logic [OW-1:0]     r_rd_offset, n_rd_offset;
    logic              r_rd_last, n_rd_last;

    logic          accept;
    logic          do_rd;
    logic          do_wr;
    logic [4:0]    loc [NB];
    logic [AW-1:0] addr [NB];

    function automatic logic [4:0] byte_loc(input logic [2:0] k, input logic [1:0] j);
        logic [4:0] b;
        logic [4:0] res;
        b = 5'({k, 1'b0}) + 5'(k) + 5'(j);
        if (b[4]) begin
            res = {b[2:0], 2'd2};
        end else begin
            res = {b[3:1], 1'b0, b[0]};
        end
        return res;
    endfunction

    assign accept  = i_valid && i_s1_free;
    assign o_ready = i_s1_free;
    assign do_rd   = accept && r_pending;
    assign do_wr   = accept && (p3te_pkg::t_opcode'(i_opcode) == p3te_pkg::OP_PIXELS);

    always_comb begin
        for (int j = 0; j < NB; j++) begin
            loc[j]              = byte_loc(r_rd_k, 2'(j));
            addr[j]             = {!r_wr_half, loc[j][4:3], r_rd_tile};
            o_meta.sel[j].odd   = loc[j][2];
            o_meta.sel[j].plane = loc[j][1:0];
        end
        o_meta.offset   = r_rd_offset;
        o_meta.last     = r_rd_last && (r_rd_k == 3'd7) && (r_rd_tile == TILE_LAST);
        o_rd_en         = do_rd;
        o_rd_addr_even  = loc[0][2] ? addr[1] : addr[0];
        o_rd_addr_odd   = loc[0][2] ? addr[0] : addr[1];
        o_rd_addr_third = addr[2];
    end

    always_comb begin
        for (int i = 0; i < p3te_pkg::PIXELS; i++) begin
            o_wr_data[3*i +: 3] = i_pixel_group[4*i +: 3];
        end
        o_wr_en   = do_wr;
        o_wr_odd  = r_wr_row[0];
        o_wr_addr = {r_wr_half, r_wr_row[2:1], r_wr_tile};
    end

    always_comb begin
        n_wr_half   = r_wr_half;
        n_wr_row    = r_wr_row;
        n_wr_tile   = r_wr_tile;
        n_wr_band   = r_wr_band;
        n_band_base = r_band_base;
        n_pending   = r_pending;
        n_rd_k      = r_rd_k;
        n_rd_tile   = r_rd_tile;
        n_rd_offset = r_rd_offset;
        n_rd_last   = r_rd_last;
        if (do_rd) begin
            n_rd_k      = r_rd_k + 3'd1;
            n_rd_offset = r_rd_offset + OW'(3);
            if (r_rd_k == 3'd7) begin
                if (r_rd_tile == TILE_LAST) begin
                    n_rd_tile = '0;
                    n_pending = 1'b0;
                end else begin
                    n_rd_tile = r_rd_tile + TILE_W'(1);
                end
            end
        end
        if (do_wr) begin
            if (r_wr_tile == TILE_LAST) begin
                n_wr_tile = '0;
                n_wr_row  = r_wr_row + 3'd1;
                if (r_wr_row == 3'd7) begin
                    n_wr_half   = !r_wr_half;
                    n_pending   = 1'b1;
                    n_rd_k      = '0;
                    n_rd_tile   = '0;
                    n_rd_offset = r_band_base;
                    n_rd_last   = (r_wr_band == BAND_LAST);
                    if (r_wr_band == BAND_LAST) begin
                        n_wr_band   = '0;
                        n_band_base = '0;
                    end else begin
                        n_wr_band   = r_wr_band + BAND_W'(1);
                        n_band_base = r_band_base + BAND_BYTES;
                    end
                end
            end else begin
                n_wr_tile = r_wr_tile + TILE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_half   <= 1'b0;
            r_wr_row    <= '0;
            r_wr_tile   <= '0;
            r_wr_band   <= '0;
            r_band_base <= '0;
            r_pending   <= 1'b0;
            r_rd_k      <= '0;
            r_rd_tile   <= '0;
            r_rd_offset <= '0;
            r_rd_last   <= 1'b0;
        end else begin
            r_wr_half   <= n_wr_half;
            r_wr_row    <= n_wr_row;
            r_wr_tile   <= n_wr_tile;
            r_wr_band   <= n_wr_band;
            r_band_base <= n_band_base;
            r_pending   <= n_pending;
            r_rd_k      <= n_rd_k;
            r_rd_tile   <= n_rd_tile;
            r_rd_offset <= n_rd_offset;
            r_rd_last   <= n_rd_last;
        end
    end

endmodule

// File: design/p3te_store.sv
module p3te_store #(
    parameter int TILES_ACROSS = p3te_pkg::TILES_ACROSS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic                         i_wr_odd,
    input  logic [((TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1)+2:0] i_wr_addr,
    input  logic [p3te_pkg::ENTRY_W-1:0] i_wr_data,
    input  logic                         i_rd_en,
    input  logic [((TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1)+2:0] i_rd_addr_even,
    input  logic [((TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1)+2:0] i_rd_addr_odd,
    input  logic [((TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1)+2:0] i_rd_addr_third,
    output logic [p3te_pkg::ENTRY_W-1:0] o_q_even,
    output logic [p3te_pkg::ENTRY_W-1:0] o_q_odd,
    output logic [p3te_pkg::ENTRY_W-1:0] o_q_even_third,
    output logic [p3te_pkg::ENTRY_W-1:0] o_q_odd_third
);

    localparam int TILE_W = (TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1;
    localparam int AW     = TILE_W + 3;
    localparam int DEPTH  = 2 ** AW;
    localparam int EW     = p3te_pkg::ENTRY_W;

    logic [EW-1:0] mem_even [DEPTH];
    logic [EW-1:0] mem_odd  [DEPTH];
    logic [EW-1:0] r_q_even, r_q_odd, r_q_even_third, r_q_odd_third;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && !i_wr_odd) begin
            mem_even[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q_even       <= mem_even[i_rd_addr_even];
            r_q_even_third <= mem_even[i_rd_addr_third];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_odd) begin
            mem_odd[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q_odd       <= mem_odd[i_rd_addr_odd];
            r_q_odd_third <= mem_odd[i_rd_addr_third];
        end
    end

    assign o_q_even       = r_q_even;
    assign o_q_odd        = r_q_odd;
    assign o_q_even_third = r_q_even_third;
    assign o_q_odd_third  = r_q_odd_third;

endmodule

// File: design/p3te_out.sv
module p3te_out (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  p3te_pkg::t_chunk_meta        i_meta,
    input  logic [p3te_pkg::ENTRY_W-1:0] i_q_even,
    input  logic [p3te_pkg::ENTRY_W-1:0] i_q_odd,
    input  logic [p3te_pkg::ENTRY_W-1:0] i_q_even_third,
    input  logic [p3te_pkg::ENTRY_W-1:0] i_q_odd_third,
    output logic                         o_s1_free,
    p3te_chunk_if.source                 o_chunk
);

    localparam int NB = p3te_pkg::CHUNK_BYTES_N;
    localparam int EW = p3te_pkg::ENTRY_W;

    logic                          r_s1_valid;
    p3te_pkg::t_chunk_meta         r_meta;
    logic                          r_o_valid;
    logic [p3te_pkg::CHUNK_W-1:0]  r_chunk;
    logic [p3te_pkg::OFFSET_W-1:0] r_offset;
    logic                          r_last;

    logic                          out_free;
    logic [EW-1:0]                 src [NB];
    logic [EW-1:0]                 shifted [NB];
    logic [p3te_pkg::CHUNK_W-1:0]  n_chunk;

    assign out_free  = !r_o_valid || o_chunk.ready;
    assign o_s1_free = !r_s1_valid || out_free;

    always_comb begin
        for (int j = 0; j < NB; j++) begin
            if (r_meta.sel[j].odd) begin
                src[j] = (j == NB - 1) ? i_q_odd_third : i_q_odd;
            end else begin
                src[j] = (j == NB - 1) ? i_q_even_third : i_q_even;
            end
            shifted[j] = src[j] >> r_meta.sel[j].plane;
            for (int i = 0; i < p3te_pkg::PIXELS; i++) begin
                n_chunk[8*j + 7 - i] = shifted[j][3*i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_s1_free) begin
                r_s1_valid <= i_rd_en;
            end
            if (out_free) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_meta <= i_meta;
        end
        if (out_free && r_s1_valid) begin
            r_chunk  <= n_chunk;
            r_offset <= r_meta.offset;
            r_last   <= r_meta.last;
        end
    end

    assign o_chunk.valid       = r_o_valid;
    assign o_chunk.chunk_bytes = r_chunk;
    assign o_chunk.byte_offset = r_offset;
    assign o_chunk.is_last     = r_last;

endmodule

// File: design/planar_3bpp_tile_encoder.sv
// Planar 3bpp tile encoder: pixel groups of eight palette indices arrive in raster order
// on i_pix (opcode 0 stores a group, opcode 1 only drains), and each accepted transaction
// made while a completed band is pending emits one 3-byte chunk of that band on o_chunk,
// tile-major, with its byte offset in the sheet and a flag on the sheet's final chunk. One
// transaction is accepted every cycle while o_chunk is taken; a chunk passes through the
// memory read register and then the output register after the transaction that causes it.
// The band store is two synchronous memories split by row parity, each with one write port
// and two read ports, so a transaction does at most one write and up to three row reads
// together. The store needs no clearing after reset.
module planar_3bpp_tile_encoder #(
    parameter int TILES_ACROSS = p3te_pkg::TILES_ACROSS_DEF,
    parameter int BAND_COUNT   = p3te_pkg::BAND_COUNT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    p3te_pix_if.sink     i_pix,
    p3te_chunk_if.source o_chunk
);

    localparam int TILE_W = (TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1;
    localparam int AW     = TILE_W + 3;
    localparam int EW     = p3te_pkg::ENTRY_W;

    logic                  s1_free;
    logic                  ready;
    logic                  wr_en;
    logic                  wr_odd;
    logic [AW-1:0]         wr_addr;
    logic [EW-1:0]         wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr_even;
    logic [AW-1:0]         rd_addr_odd;
    logic [AW-1:0]         rd_addr_third;
    p3te_pkg::t_chunk_meta meta;
    logic [EW-1:0]         q_even;
    logic [EW-1:0]         q_odd;
    logic [EW-1:0]         q_even_third;
    logic [EW-1:0]         q_odd_third;

    assign i_pix.ready = ready;

    p3te_ctrl #(
        .TILES_ACROSS (TILES_ACROSS),
        .BAND_COUNT   (BAND_COUNT)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_pix.valid),
        .i_opcode        (i_pix.opcode),
        .i_pixel_group   (i_pix.pixel_group),
        .i_s1_free       (s1_free),
        .o_ready         (ready),
        .o_wr_en         (wr_en),
        .o_wr_odd        (wr_odd),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data),
        .o_rd_en         (rd_en),
        .o_rd_addr_even  (rd_addr_even),
        .o_rd_addr_odd   (rd_addr_odd),
        .o_rd_addr_third (rd_addr_third),
        .o_meta          (meta)
    );

    p3te_store #(
        .TILES_ACROSS (TILES_ACROSS)
    ) u_store (
        .i_clk           (i_clk),
        .i_wr_en         (wr_en),
        .i_wr_odd        (wr_odd),
        .i_wr_addr       (wr_addr),
        .i_wr_data       (wr_data),
        .i_rd_en         (rd_en),
        .i_rd_addr_even  (rd_addr_even),
        .i_rd_addr_odd   (rd_addr_odd),
        .i_rd_addr_third (rd_addr_third),
        .o_q_even        (q_even),
        .o_q_odd         (q_odd),
        .o_q_even_third  (q_even_third),
        .o_q_odd_third   (q_odd_third)
    );

    p3te_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rd_en        (rd_en),
        .i_meta         (meta),
        .i_q_even       (q_even),
        .i_q_odd        (q_odd),
        .i_q_even_third (q_even_third),
        .i_q_odd_third  (q_odd_third),
        .o_s1_free      (s1_free),
        .o_chunk        (o_chunk)
    );

endmodule

// File: design/p3te_checker.sv
module p3te_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [p3te_pkg::CHUNK_W-1:0]  i_out_chunk,
    input logic [p3te_pkg::OFFSET_W-1:0] i_out_offset,
    input logic                          i_out_last
);

    localparam int OW = p3te_pkg::OFFSET_W;

    logic [OW-1:0] r_exp_offset;
    logic          out_acc;

    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_offset <= '0;
        end else if (out_acc) begin
            r_exp_offset <= i_out_last ? '0 : i_out_offset + OW'(3);
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("chunk valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_chunk)
            && $stable(i_out_offset) && $stable(i_out_last))
        else $error("stalled chunk changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    a_offset_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> i_out_offset == r_exp_offset)
        else $error("chunk offset out of order");

    a_no_spurious_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("pending chunk lost on input transaction");

endmodule

bind planar_3bpp_tile_encoder p3te_checker u_p3te_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pix.valid),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_chunk.valid),
    .i_out_ready  (o_chunk.ready),
    .i_out_chunk  (o_chunk.chunk_bytes),
    .i_out_offset (o_chunk.byte_offset),
    .i_out_last   (o_chunk.is_last)
);

// File: tb/planar_3bpp_tile_encoder_test.sv
module planar_3bpp_tile_encoder_test;

    localparam int TILES        = p3te_pkg::TILES_ACROSS_DEF;
    localparam int BANDS        = p3te_pkg::BAND_COUNT_DEF;
    localparam int GW           = p3te_pkg::GROUP_W;
    localparam int EW           = p3te_pkg::ENTRY_W;
    localparam int OW           = p3te_pkg::OFFSET_W;
    localparam int BAND_ENTRIES = TILES * 8;
    localparam int STORE_DEPTH  = 2 * BAND_ENTRIES;
    localparam int TILE_BYTES   = 24;
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 140;
    localparam int DRAIN_PCT    = 12;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [p3te_pkg::CHUNK_W-1:0] bytes;
        logic [OW-1:0]                offset;
        logic                         last;
    } t_chunk;

    class t_chunk_scoreboard;
        logic [EW-1:0] band_mem [STORE_DEPTH];
        int     wr_pos;
        int     wr_band;
        int     rd_chunk;
        int     rd_band;
        bit     band_ready;
        t_chunk chunks_due [$];
        int     mismatches;

        function new();
            wr_pos     = 0;
            wr_band    = 0;
            rd_chunk   = 0;
            rd_band    = 0;
            band_ready = 1'b0;
            mismatches = 0;
        endfunction

        function logic [7:0] plane_bits(logic [EW-1:0] entry, int plane);
            logic [7:0] bits;
            bits = '0;
            for (int i = 0; i < p3te_pkg::PIXELS; i++) begin
                bits[7-i] = entry[3*i+plane];
            end
            return bits;
        endfunction

        function void note_input(p3te_pkg::t_opcode op, logic [GW-1:0] grp);
            t_chunk        c;
            int            base;
            int            tile;
            int            byte_idx;
            int            row;
            int            plane;
            logic [EW-1:0] entry;
            if (band_ready) begin
                base = (1 - wr_pos / BAND_ENTRIES) * BAND_ENTRIES;
                tile = rd_chunk / 8;
                c.bytes = '0;
                for (int j = 0; j < p3te_pkg::CHUNK_BYTES_N; j++) begin
                    byte_idx = 3 * (rd_chunk % 8) + j;
                    if (byte_idx < 16) begin
                        row   = byte_idx / 2;
                        plane = byte_idx % 2;
                    end else begin
                        row   = byte_idx - 16;
                        plane = 2;
                    end
                    c.bytes[8*j +: 8] =
                        plane_bits(band_mem[(base + row * TILES + tile) % STORE_DEPTH], plane);
                end
                c.offset = OW'(rd_band * TILES * TILE_BYTES + rd_chunk * 3);
                c.last   = (rd_chunk == BAND_ENTRIES - 1) && (rd_band == BANDS - 1);
                chunks_due.push_back(c);
                if (rd_chunk == BAND_ENTRIES - 1) begin
                    band_ready = 1'b0;
                    rd_chunk   = 0;
                end else begin
                    rd_chunk++;
                end
            end
            if (op == p3te_pkg::OP_PIXELS) begin
                for (int i = 0; i < p3te_pkg::PIXELS; i++) begin
                    entry[3*i +: 3] = grp[4*i +: 3];
                end
                band_mem[wr_pos] = entry;
                wr_pos = (wr_pos + 1) % STORE_DEPTH;
                if (wr_pos % BAND_ENTRIES == 0) begin
                    band_ready = 1'b1;
                    rd_chunk   = 0;
                    rd_band    = wr_band;
                    wr_band    = (wr_band + 1) % BANDS;
                end
            end
        endfunction

        function void check_chunk(t_chunk got);
            t_chunk want;
            if (chunks_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected chunk: bytes %h offset %0d last %0b",
                             got.bytes, got.offset, got.last);
                end
                return;
            end
            want = chunks_due.pop_front();
            if (got.bytes !== want.bytes || got.offset !== want.offset
                    || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("chunk mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                             want.bytes, want.offset, want.last,
                             got.bytes, got.offset, got.last);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    p3te_pix_if   pix_bus ();
    p3te_chunk_if chunk_bus ();

    planar_3bpp_tile_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_chunk (chunk_bus)
    );

    t_chunk_scoreboard sb;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    bit hold_req        = 1'b0;
    int quiet_cycles    = 0;

    logic [GW-1:0] corner_groups [14] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h7777_7777, 32'h8888_8888,
        32'h7654_3210, 32'h0123_4567, 32'hFEDC_BA98, 32'h1111_1111,
        32'h2222_2222, 32'h4444_4444, 32'h0000_0007, 32'h7000_0000,
        32'hA5A5_A5A5, 32'h5A5A_5A5A
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && chunk_bus.valid && chunk_bus.ready) begin
            sb.check_chunk(t_chunk'{chunk_bus.chunk_bytes, chunk_bus.byte_offset,
                                    chunk_bus.is_last});
        end
    end

    always @(posedge i_clk) begin
        if ((pix_bus.valid && pix_bus.ready) || (chunk_bus.valid && chunk_bus.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        chunk_bus.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                chunk_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            chunk_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(p3te_pkg::t_opcode op, logic [GW-1:0] grp);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            pix_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_bus.valid       <= 1'b1;
        pix_bus.opcode      <= op;
        pix_bus.pixel_group <= grp;
        do begin
            @(posedge i_clk);
        end while (!pix_bus.ready);
        sb.note_input(op, grp);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        pix_bus.valid <= 1'b0;
        while (sb.chunks_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_items(int count, int idle_pct, int stall_pct);
        p3te_pkg::t_opcode op;
        logic [GW-1:0]     grp;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        repeat (count) begin
            op = ($urandom_range(99) < DRAIN_PCT) ? p3te_pkg::OP_DRAIN : p3te_pkg::OP_PIXELS;
            case ($urandom_range(9))
                0:       grp = '0;
                1:       grp = '1;
                default: grp = $urandom();
            endcase
            send_item(op, grp);
        end
        wait_drained();
    endtask

    initial begin
        sb = new();
        pix_bus.valid       <= 1'b0;
        pix_bus.opcode      <= p3te_pkg::OP_PIXELS;
        pix_bus.pixel_group <= '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(p3te_pkg::OP_DRAIN, 32'hFFFF_FFFF);
        send_item(p3te_pkg::OP_DRAIN, 32'h0000_0000);
        foreach (corner_groups[i]) begin
            send_item(p3te_pkg::OP_PIXELS, corner_groups[i]);
        end
        send_item(p3te_pkg::OP_DRAIN, 32'h8421_8421);

        send_random_items(PHASE_ITEMS, 0, 0);
        send_random_items(PHASE_ITEMS, 63, 0);
        send_random_items(PHASE_ITEMS, 0, 63);
        send_random_items(PHASE_ITEMS, 28, 28);
        hold_req = 1'b1;
        send_random_items(PHASE_ITEMS, 0, 0);

        // flush the band still waiting for its chunks
        while (sb.band_ready) send_item(p3te_pkg::OP_DRAIN, $urandom());
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.chunks_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
